// ----- rtl/tlbc_pkg.sv -----
// Package for the two-level Bloch cell update: payload structs, register
// indexes and the saturating Q8.24 arithmetic helpers.
// No dependencies.
package tlbc_pkg;

    localparam int QW = 32;
    localparam int FRAC_BITS = 24;
    localparam int CORRECTOR_PASSES = 4;
    localparam int NUM_REGS = 8;
    localparam int IDX_W = 3;
    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [QW-1:0] q_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DIPOLE    = 3'd0,
        REG_TIME_STEP = 3'd1,
        REG_RELAX     = 3'd2,
        REG_FREQ      = 3'd3,
        REG_DEPHASE   = 3'd4,
        REG_POL_GAIN  = 3'd5,
        REG_E_GAIN    = 3'd6,
        REG_INV_DX    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        q_t   dipole_scaled;
        q_t   time_step;
        q_t   relax_rate;
        q_t   transition_freq;
        q_t   dephase_rate;
        q_t   polarization_gain;
        q_t   efield_gain;
        q_t   inv_cell_size;
    } cfg_t;

    typedef struct packed {
        q_t   pop_lower;
        q_t   pop_upper;
        q_t   coh_real;
        q_t   coh_imag;
        q_t   efield_old;
        q_t   hfield_left;
        q_t   hfield_right;
        logic is_source_cell;
        q_t   source_value;
    } cell_in_t;

    typedef struct packed {
        q_t pop_lower_new;
        q_t pop_upper_new;
        q_t coh_real_new;
        q_t coh_imag_new;
        q_t efield_new;
    } cell_out_t;

    // Running estimates that one pass hands to the next.
    typedef struct packed {
        q_t   o11;
        q_t   o22;
        q_t   orr;
        q_t   oi;
        q_t   oe;
        q_t   e11;
        q_t   e22;
        q_t   er;
        q_t   ei;
        q_t   ee;
        q_t   curl;
        q_t   cpd;
        logic src_cell;
        q_t   src;
    } est_t;

    // Saturate a 34-bit sum to the Q8.24 range.
    function automatic q_t sat34(input logic signed [QW+1:0] v);
        if (v > 34'(Q_MAX))
            return Q_MAX;
        else if (v < 34'(Q_MIN))
            return Q_MIN;
        else
            return v[QW-1:0];
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        return sat34(34'(a) + 34'(b));
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return sat34(34'(a) - 34'(b));
    endfunction

    // Average rounded half toward plus infinity.
    function automatic q_t qavg(input q_t a, input q_t b);
        logic signed [QW+1:0] s;
        s = 34'(a) + 34'(b) + 34'sd1;
        return s[QW:1];
    endfunction

    // Product rescaled by 2^-24, rounded half up, saturated.
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [2*QW-1:0] p;
        logic signed [2*QW-FRAC_BITS-1:0] r;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        r = p[2*QW-1:FRAC_BITS];
        if (r > 40'(Q_MAX))
            return Q_MAX;
        else if (r < 40'(Q_MIN))
            return Q_MIN;
        else
            return r[QW-1:0];
    endfunction

endpackage

// ----- rtl/tlbc_pass.sv -----
// One predictor-corrector pass cut into four register stages.
// Depends on tlbc_pkg.
module tlbc_pass (
    input  logic          clk,
    input  logic          rst_n,
    input  tlbc_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  tlbc_pkg::est_t in_est,
    output logic          out_valid,
    output tlbc_pkg::est_t out_est
);
    import tlbc_pkg::*;

    logic [3:0] vld_reg;
    est_t s1_reg, s2_reg, s3_reg, s4_reg;
    q_t a11_reg, a22_reg, ar_reg, ai_reg, om_reg;
    q_t omi_reg, t11_reg, wai_reg, war_reg, gar_reg, gai_reg, omd_reg, a11b_reg;
    q_t d11_reg, di_reg, dr_reg, d22_reg, pt_reg;

    // Valid bits follow the data through the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    // Stage 1: averages and Rabi term.
    always_ff @(posedge clk)
    begin
        s1_reg  <= in_est;
        a11_reg <= qavg(in_est.o11, in_est.e11);
        a22_reg <= qavg(in_est.o22, in_est.e22);
        ar_reg  <= qavg(in_est.orr, in_est.er);
        ai_reg  <= qavg(in_est.oi, in_est.ei);
        om_reg  <= qmul(cfg.dipole_scaled, qavg(in_est.oe, in_est.ee));
    end

    // Stage 2: products of the averages.
    always_ff @(posedge clk)
    begin
        s2_reg  <= s1_reg;
        omi_reg <= qmul(om_reg, ai_reg);
        t11_reg <= qmul(cfg.relax_rate, a11_reg);
        wai_reg <= qmul(cfg.transition_freq, ai_reg);
        war_reg <= qmul(cfg.transition_freq, ar_reg);
        gar_reg <= qmul(cfg.dephase_rate, ar_reg);
        gai_reg <= qmul(cfg.dephase_rate, ai_reg);
        omd_reg <= qmul(om_reg, qsub(a11_reg, a22_reg));
        a11b_reg <= a11_reg;
    end

    // Stage 3: derivatives and polarization current. The di sum is formed
    // exactly in 34 bits and saturated once; d11 and d22 use a saturated om2i.
    always_ff @(posedge clk)
    begin
        q_t om2i;
        q_t dr;
        om2i = qadd(omi_reg, omi_reg);
        dr = qsub(wai_reg, gar_reg);
        s3_reg  <= s2_reg;
        d11_reg <= sat34(-34'(om2i) - 34'(t11_reg));
        di_reg  <= sat34(-34'(war_reg) + 34'(omd_reg) - 34'(gai_reg));
        dr_reg  <= dr;
        d22_reg <= qadd(om2i, t11_reg);
        pt_reg  <= qmul(s2_reg.cpd, dr);
    end

    // Stage 4: new estimates, source cell forces the field.
    always_ff @(posedge clk)
    begin
        est_t n;
        n = s3_reg;
        n.e11 = qadd(s3_reg.o11, qmul(cfg.time_step, d11_reg));
        n.ei  = qadd(s3_reg.oi, qmul(cfg.time_step, di_reg));
        n.er  = qadd(s3_reg.orr, qmul(cfg.time_step, dr_reg));
        n.e22 = qadd(s3_reg.o22, qmul(cfg.time_step, d22_reg));
        n.ee  = s3_reg.src_cell ? s3_reg.src
                : qadd(s3_reg.oe, qmul(cfg.efield_gain, qsub(s3_reg.curl, pt_reg)));
        s4_reg <= n;
    end

    assign out_valid = vld_reg[3];
    assign out_est   = s4_reg;

`ifndef SYNTHESIS
    a_vld_shift: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##4 out_valid) else $error("pass lost an item");
    a_vld_none: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |-> ##4 !out_valid) else $error("pass invented an item");
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && s3_reg.src_cell |=> s4_reg.ee == $past(s3_reg.src))
        else $error("source field not forced");
`endif
endmodule

// ----- rtl/two_level_bloch_cell_update.sv -----
// Top level of the two-level Bloch cell update: config registers, set-up
// stage and a chain of pass pipelines. Depends on tlbc_pkg and tlbc_pass.
//
// One cell is accepted every clock cycle (busy is always low). A result is
// transferred with done high once the cell has passed through the two set-up
// stages, four stages per pass and the output register.
// The output cannot be stalled; done marks a single-cycle transfer.
module two_level_bloch_cell_update (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tlbc_pkg::cell_in_t   cell_in,
    output logic                 done,
    output tlbc_pkg::cell_out_t  cell_out,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_idx,
    input  logic [31:0]          cfg_data
);
    import tlbc_pkg::*;

    cfg_t cfg_reg;
    logic [1:0] pre_vld_reg;
    cell_in_t p0_reg;
    q_t dif_reg, cpd_reg;
    est_t p1_reg;
    logic [CORRECTOR_PASSES:0] vld;
    est_t est [CORRECTOR_PASSES+1];
    logic done_reg;
    cell_out_t out_reg;

    assign busy = 1'b0;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_DIPOLE:    cfg_reg.dipole_scaled     <= cfg_data;
                REG_TIME_STEP: cfg_reg.time_step         <= cfg_data;
                REG_RELAX:     cfg_reg.relax_rate        <= cfg_data;
                REG_FREQ:      cfg_reg.transition_freq   <= cfg_data;
                REG_DEPHASE:   cfg_reg.dephase_rate      <= cfg_data;
                REG_POL_GAIN:  cfg_reg.polarization_gain <= cfg_data;
                REG_E_GAIN:    cfg_reg.efield_gain       <= cfg_data;
                REG_INV_DX:    cfg_reg.inv_cell_size     <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Set-up valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_vld_reg <= '0;
        else
            pre_vld_reg <= {pre_vld_reg[0], start && !busy};
    end

    // Set-up stage 1: H difference and coupling product.
    always_ff @(posedge clk)
    begin
        p0_reg  <= cell_in;
        dif_reg <= qsub(cell_in.hfield_right, cell_in.hfield_left);
        cpd_reg <= qmul(cfg_reg.polarization_gain, cfg_reg.dipole_scaled);
    end

    // Set-up stage 2: curl and initial estimates.
    always_ff @(posedge clk)
    begin
        p1_reg.o11 <= p0_reg.pop_lower;
        p1_reg.o22 <= p0_reg.pop_upper;
        p1_reg.orr <= p0_reg.coh_real;
        p1_reg.oi  <= p0_reg.coh_imag;
        p1_reg.oe  <= p0_reg.efield_old;
        p1_reg.e11 <= p0_reg.pop_lower;
        p1_reg.e22 <= p0_reg.pop_upper;
        p1_reg.er  <= p0_reg.coh_real;
        p1_reg.ei  <= p0_reg.coh_imag;
        p1_reg.ee  <= p0_reg.efield_old;
        p1_reg.curl <= qmul(dif_reg, cfg_reg.inv_cell_size);
        p1_reg.cpd  <= cpd_reg;
        p1_reg.src_cell <= p0_reg.is_source_cell;
        p1_reg.src  <= p0_reg.source_value;
    end

    assign vld[0] = pre_vld_reg[1];
    assign est[0] = p1_reg;

    // Chain of corrector passes.
    for (genvar k = 0; k < CORRECTOR_PASSES; k++)
    begin : g_pass
        tlbc_pass u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg_reg),
            .in_valid  (vld[k]),
            .in_est    (est[k]),
            .out_valid (vld[k+1]),
            .out_est   (est[k+1])
        );
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld[CORRECTOR_PASSES];
    end

    always_ff @(posedge clk)
    begin
        out_reg.pop_lower_new <= est[CORRECTOR_PASSES].e11;
        out_reg.pop_upper_new <= est[CORRECTOR_PASSES].e22;
        out_reg.coh_real_new  <= est[CORRECTOR_PASSES].er;
        out_reg.coh_imag_new  <= est[CORRECTOR_PASSES].ei;
        out_reg.efield_new    <= est[CORRECTOR_PASSES].ee;
    end

    assign done     = done_reg;
    assign cell_out = out_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(3 + 4*CORRECTOR_PASSES) done) else $error("result lost");
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(3 + 4*CORRECTOR_PASSES) !done) else $error("result invented");
    a_setup: assert property (@(posedge clk) disable iff (!rst_n)
        pre_vld_reg[1] |=> g_pass[0].u_pass.vld_reg[0]) else $error("set-up slip");
`endif
endmodule
